>>> rtl/tpit_pkg.sv
`timescale 1ns / 1ps
// Package for the time-partition interval table unit.
// Holds the request and status codes, the sequencer states and the slot entry type.
// Used by tpit_div and time_partition_interval_table_unit.
package tpit_pkg;

	localparam int unsigned NUM_MODES_DEF      = 4;
	localparam int unsigned SLOTS_PER_MODE_DEF = 16;
	localparam int unsigned TW                 = 64;
	localparam int unsigned CPU_W              = 8;

	localparam logic [TW-1:0] MAJOR_RESET  = 64'd1000000;
	localparam logic [TW-1:0] PERIOD_RESET = 64'd0;
	localparam logic [TW-1:0] ALL_ONES     = ~64'd0;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_FIND  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ORDER   = 3'd1;
	localparam logic [2:0] ST_MAJOR   = 3'd2;
	localparam logic [2:0] ST_PERIOD  = 3'd3;
	localparam logic [2:0] ST_OVERLAP = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;

	typedef struct packed {
		logic [TW-1:0]    start;
		logic [TW-1:0]    stop;
		logic [CPU_W-1:0] cpu;
	} slot_entry_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ADIV,
		S_AMAJ,
		S_APDIV,
		S_APCMP,
		S_AMODE,
		S_WRD,
		S_WEV,
		S_ADEC,
		S_SHRD,
		S_SHWR,
		S_INS,
		S_FDIV,
		S_FBASE,
		S_FBASE2,
		S_FRD,
		S_FE1,
		S_FE2,
		S_FE3,
		S_DONE
	} seq_state_t;

endpackage

>>> rtl/tpit_div.sv
`timescale 1ns / 1ps
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on tpit_pkg for the operand width.
module tpit_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [tpit_pkg::TW-1:0] dividend,
	input  logic [tpit_pkg::TW-1:0] divisor,
	output logic                  done,
	output logic [tpit_pkg::TW-1:0] quo,
	output logic [tpit_pkg::TW-1:0] rem
);

	localparam int unsigned W  = tpit_pkg::TW;
	localparam int unsigned CW = $clog2(W);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          take;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= take ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

>>> rtl/time_partition_interval_table_unit.sv
`timescale 1ns / 1ps
// Top level of the time-partition interval table: request sequencer, slot memory,
// configuration registers and output register. Depends on tpit_pkg and tpit_div.
//
//  channel   | handshake                    | payload
//  request   | in_valid / in_stall          | req_type, time_or_start, end_time, cpu_num, crit_mode
//  result    | out_valid / out_stall        | status ... ends_cycle, one per request
//  config    | psel, penable, pwrite, pready| paddr, pwdata, prdata (64 bits)
//
// One request at a time. An add waits on a divide by the major cycle (and on one by the
// period when the period check is on), walks the stored entries, moves the entries behind
// the insert point and writes the new one. A find waits on its divide and then visits the
// stored entries; a clear or an unknown request goes straight to the result.
// The divider is shared by adds and finds; the slot memory has one read and one write port.
// Reset empties all tables at once through the counts; no clearing pass is needed.
// in_stall is high while a request is in work; a finished result waits in the output register.
module time_partition_interval_table_unit #(
	parameter int unsigned NUM_MODES      = tpit_pkg::NUM_MODES_DEF,
	parameter int unsigned SLOTS_PER_MODE = tpit_pkg::SLOTS_PER_MODE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [63:0] time_or_start,
	input  logic [63:0] end_time,
	input  logic [7:0]  cpu_num,
	input  logic [3:0]  crit_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        inside_res,
	output logic        has_interval,
	output logic [3:0]  slot,
	output logic [63:0] cycle_base,
	output logic [63:0] iv_start,
	output logic [63:0] iv_end,
	output logic [7:0]  iv_cpu,
	output logic        ends_cycle,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int unsigned TW    = tpit_pkg::TW;
	localparam int unsigned DEPTH = NUM_MODES * SLOTS_PER_MODE;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned MW    = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
	localparam int unsigned IW    = (SLOTS_PER_MODE > 1) ? $clog2(SLOTS_PER_MODE) : 1;
	localparam int unsigned CW    = $clog2(SLOTS_PER_MODE + 1);
	localparam int unsigned MMW   = $clog2(NUM_MODES + 1);

	tpit_pkg::seq_state_t state_q, state_d;

	// Configuration registers.
	logic [TW-1:0] major_q;
	logic [TW-1:0] period_q;
	logic [TW-1:0] meff;

	// Table bookkeeping.
	logic [CW-1:0]  mode_count_q [NUM_MODES];
	logic [MMW-1:0] modes_made_q;

	// Request operands.
	logic [TW-1:0] st_q;
	logic [7:0]    cpu_q;
	logic [3:0]    crit_q;
	logic [TW-1:0] d_q;
	logic [TW-1:0] q_q;
	logic [TW-1:0] r_q;
	logic [TW-1:0] mr_q;
	logic [TW-1:0] pmr_q;
	logic [TW-1:0] en_off_q;
	logic [MW-1:0] mode_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] j_q;
	logic          has_next_q;
	logic [TW-1:0] next_start_q;
	logic [TW-1:0] prev_end_q;

	// Find walk.
	logic [TW-1:0] cbase_q;
	logic [TW-1:0] cbm_q;
	logic [TW-1:0] s0_q;
	logic [TW-1:0] e0_q;
	logic [TW-1:0] s_q;
	logic [TW-1:0] cyc_q;
	logic          brk_q;
	logic [TW-1:0] delay_q;
	logic          hit_inside;
	logic          hit_better;

	// Result staging.
	logic [2:0]    res_status_q;
	logic          res_has_q;
	logic          res_inside_q;
	logic [CW-1:0] best_q;
	logic [TW-1:0] best_cyc_q;
	tpit_pkg::slot_entry_t best_ent_q;

	// Slot memory.
	tpit_pkg::slot_entry_t mem [DEPTH];
	tpit_pkg::slot_entry_t rd_q;
	logic                  mem_re;
	logic                  mem_we;
	logic [AW-1:0]         mem_raddr;
	logic [AW-1:0]         mem_waddr;
	tpit_pkg::slot_entry_t mem_wdata;

	// Divider.
	logic          div_start;
	logic [TW-1:0] div_dvd;
	logic [TW-1:0] div_dvs;
	logic          div_done;
	logic [TW-1:0] div_quo;
	logic [TW-1:0] div_rem;

	logic in_acc;
	logic out_free;
	logic cfg_wr;
	logic mode_ok;
	logic mode_fits;
	logic overlap;

	function automatic logic [AW-1:0] slot_addr(input logic [MW-1:0] m, input logic [CW-1:0] idx);
		slot_addr = AW'(m) * AW'(SLOTS_PER_MODE) + AW'(idx);
	endfunction

	assign meff     = (major_q == '0) ? TW'(1) : major_q;
	assign in_stall = (state_q != tpit_pkg::S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign prdata   = paddr[3] ? period_q : major_q;

	assign mode_ok    = 5'(crit_q) < 5'(modes_made_q);
	assign mode_fits  = q_q < TW'(NUM_MODES);
	assign overlap    = (has_next_q && (en_off_q > next_start_q)) ||
	                    ((pos_q != '0) && (prev_end_q > r_q));
	assign hit_inside = s_q <= st_q;
	assign hit_better = hit_inside || ((s_q - st_q) < delay_q);

	tpit_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q  <= tpit_pkg::MAJOR_RESET;
			period_q <= tpit_pkg::PERIOD_RESET;
		end else if (cfg_wr) begin
			if (paddr[3]) begin
				period_q <= pwdata;
			end else begin
				major_q <= pwdata;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tpit_pkg::S_IDLE: begin
				if (in_acc) begin
					case (req_type)
						tpit_pkg::REQ_ADD:  state_d = (time_or_start >= end_time) ?
						                              tpit_pkg::S_DONE : tpit_pkg::S_ADIV;
						tpit_pkg::REQ_FIND: state_d = tpit_pkg::S_FDIV;
						default:            state_d = tpit_pkg::S_DONE;
					endcase
				end
			end
			tpit_pkg::S_ADIV:   if (div_done) state_d = tpit_pkg::S_AMAJ;
			tpit_pkg::S_AMAJ: begin
				if (d_q >= mr_q) begin
					state_d = tpit_pkg::S_DONE;
				end else if (period_q != '0) begin
					state_d = tpit_pkg::S_APDIV;
				end else begin
					state_d = tpit_pkg::S_AMODE;
				end
			end
			tpit_pkg::S_APDIV:  if (div_done) state_d = tpit_pkg::S_APCMP;
			tpit_pkg::S_APCMP:  state_d = (d_q >= pmr_q) ? tpit_pkg::S_DONE : tpit_pkg::S_AMODE;
			tpit_pkg::S_AMODE:  state_d = mode_fits ? tpit_pkg::S_WRD : tpit_pkg::S_DONE;
			tpit_pkg::S_WRD:    state_d = (i_q < cnt_q) ? tpit_pkg::S_WEV : tpit_pkg::S_ADEC;
			tpit_pkg::S_WEV:    state_d = (rd_q.start > r_q) ? tpit_pkg::S_ADEC : tpit_pkg::S_WRD;
			tpit_pkg::S_ADEC: begin
				if (overlap || (cnt_q >= CW'(SLOTS_PER_MODE))) begin
					state_d = tpit_pkg::S_DONE;
				end else begin
					state_d = tpit_pkg::S_SHRD;
				end
			end
			tpit_pkg::S_SHRD:   state_d = (j_q > pos_q) ? tpit_pkg::S_SHWR : tpit_pkg::S_INS;
			tpit_pkg::S_SHWR:   state_d = tpit_pkg::S_SHRD;
			tpit_pkg::S_INS:    state_d = tpit_pkg::S_DONE;
			tpit_pkg::S_FDIV:   if (div_done) state_d = tpit_pkg::S_FBASE;
			tpit_pkg::S_FBASE:  state_d = mode_ok ? tpit_pkg::S_FBASE2 : tpit_pkg::S_DONE;
			tpit_pkg::S_FBASE2: state_d = tpit_pkg::S_FRD;
			tpit_pkg::S_FRD:    state_d = (i_q < cnt_q) ? tpit_pkg::S_FE1 : tpit_pkg::S_DONE;
			tpit_pkg::S_FE1:    state_d = tpit_pkg::S_FE2;
			tpit_pkg::S_FE2:    state_d = tpit_pkg::S_FE3;
			tpit_pkg::S_FE3: begin
				if ((hit_better && hit_inside) || brk_q) begin
					state_d = tpit_pkg::S_DONE;
				end else begin
					state_d = tpit_pkg::S_FRD;
				end
			end
			tpit_pkg::S_DONE:   if (out_free) state_d = tpit_pkg::S_IDLE;
			default:            state_d = tpit_pkg::S_IDLE;
		endcase
	end

	// Memory and divider controls.
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = slot_addr(mode_q, i_q);
		mem_waddr = slot_addr(mode_q, j_q);
		mem_wdata = rd_q;
		div_start = 1'b0;
		div_dvd   = st_q;
		div_dvs   = period_q;
		case (state_q)
			tpit_pkg::S_IDLE: begin
				div_dvd   = time_or_start;
				div_dvs   = meff;
				div_start = in_acc && ((req_type == tpit_pkg::REQ_FIND) ||
				            ((req_type == tpit_pkg::REQ_ADD) && (time_or_start < end_time)));
			end
			tpit_pkg::S_AMAJ: div_start = (d_q < mr_q) && (period_q != '0);
			tpit_pkg::S_WRD:  mem_re = i_q < cnt_q;
			tpit_pkg::S_FRD:  mem_re = i_q < cnt_q;
			tpit_pkg::S_SHRD: begin
				mem_raddr = slot_addr(mode_q, j_q - 1'b1);
				mem_re    = j_q > pos_q;
			end
			tpit_pkg::S_SHWR: mem_we = 1'b1;
			tpit_pkg::S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = slot_addr(mode_q, pos_q);
				mem_wdata = '{start: r_q, stop: en_off_q, cpu: cpu_q};
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tpit_pkg::S_IDLE;
			modes_made_q <= '0;
			out_valid    <= 1'b0;
			for (int k = 0; k < NUM_MODES; k++) begin
				mode_count_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == tpit_pkg::S_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (in_acc && req_type == tpit_pkg::REQ_CLEAR) begin
				modes_made_q <= '0;
				for (int k = 0; k < NUM_MODES; k++) begin
					mode_count_q[k] <= '0;
				end
			end
			if (state_q == tpit_pkg::S_AMODE && mode_fits &&
			    modes_made_q < MMW'(q_q[MW-1:0]) + 1'b1) begin
				modes_made_q <= MMW'(q_q[MW-1:0]) + 1'b1;
			end
			if (state_q == tpit_pkg::S_INS) begin
				mode_count_q[mode_q] <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			tpit_pkg::S_IDLE: begin
				if (in_acc) begin
					st_q         <= time_or_start;
					cpu_q        <= cpu_num;
					crit_q       <= crit_mode;
					d_q          <= end_time - time_or_start;
					res_has_q    <= 1'b0;
					res_inside_q <= 1'b0;
					res_status_q <= ((req_type == tpit_pkg::REQ_ADD) && (time_or_start >= end_time)) ?
					                tpit_pkg::ST_ORDER : tpit_pkg::ST_OK;
				end
			end
			tpit_pkg::S_ADIV: begin
				if (div_done) begin
					q_q  <= div_quo;
					r_q  <= div_rem;
					mr_q <= meff - div_rem;
				end
			end
			tpit_pkg::S_AMAJ: begin
				en_off_q <= r_q + d_q;
				if (d_q >= mr_q) begin
					res_status_q <= tpit_pkg::ST_MAJOR;
				end
			end
			tpit_pkg::S_APDIV: begin
				if (div_done) begin
					pmr_q <= period_q - div_rem;
				end
			end
			tpit_pkg::S_APCMP: begin
				if (d_q >= pmr_q) begin
					res_status_q <= tpit_pkg::ST_PERIOD;
				end
			end
			tpit_pkg::S_AMODE: begin
				mode_q     <= q_q[MW-1:0];
				cnt_q      <= mode_count_q[q_q[MW-1:0]];
				i_q        <= '0;
				has_next_q <= 1'b0;
				if (!mode_fits) begin
					res_status_q <= tpit_pkg::ST_FULL;
				end
			end
			tpit_pkg::S_WRD: begin
				if (i_q >= cnt_q) begin
					pos_q <= cnt_q;
				end
			end
			tpit_pkg::S_WEV: begin
				if (rd_q.start > r_q) begin
					pos_q        <= i_q;
					has_next_q   <= 1'b1;
					next_start_q <= rd_q.start;
				end else begin
					prev_end_q <= rd_q.stop;
					i_q        <= i_q + 1'b1;
				end
			end
			tpit_pkg::S_ADEC: begin
				j_q <= cnt_q;
				if (overlap) begin
					res_status_q <= tpit_pkg::ST_OVERLAP;
				end else if (cnt_q >= CW'(SLOTS_PER_MODE)) begin
					res_status_q <= tpit_pkg::ST_FULL;
				end
			end
			tpit_pkg::S_SHWR: j_q <= j_q - 1'b1;
			tpit_pkg::S_FDIV: begin
				if (div_done) begin
					r_q <= div_rem;
				end
			end
			tpit_pkg::S_FBASE: begin
				cbase_q <= st_q - r_q;
				mode_q  <= crit_q[MW-1:0];
				cnt_q   <= mode_count_q[crit_q[MW-1:0]];
				i_q     <= '0;
				delay_q <= tpit_pkg::ALL_ONES;
			end
			tpit_pkg::S_FBASE2: cbm_q <= cbase_q + meff;
			tpit_pkg::S_FE1: begin
				s0_q <= cbase_q + rd_q.start;
				e0_q <= cbase_q + rd_q.stop;
			end
			tpit_pkg::S_FE2: begin
				// An interval already over in this major cycle is taken from the next one.
				s_q   <= (e0_q < st_q) ? s0_q + meff : s0_q;
				cyc_q <= (e0_q < st_q) ? cbm_q : cbase_q;
				brk_q <= s0_q > st_q;
			end
			tpit_pkg::S_FE3: begin
				if (hit_better) begin
					res_has_q    <= 1'b1;
					res_inside_q <= hit_inside;
					best_q       <= i_q;
					best_cyc_q   <= cyc_q;
					best_ent_q   <= rd_q;
					delay_q      <= s_q - st_q;
				end
				i_q <= i_q + 1'b1;
			end
			default: begin
				i_q <= i_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == tpit_pkg::S_DONE && out_free) begin
			status       <= res_status_q;
			has_interval <= res_has_q;
			inside_res   <= res_has_q && res_inside_q;
			slot         <= res_has_q ? 4'(best_q) : 4'd0;
			cycle_base   <= res_has_q ? best_cyc_q : '0;
			iv_start     <= res_has_q ? best_ent_q.start : '0;
			iv_end       <= res_has_q ? best_ent_q.stop : '0;
			iv_cpu       <= res_has_q ? best_ent_q.cpu : '0;
			ends_cycle   <= res_has_q && ((best_q + 1'b1) == cnt_q);
		end
	end

endmodule

>>> tb/tpit_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the time-partition interval table unit: follows the register port,
// predicts each result from its own copy of the tables and compares it with the DUT.
// Depends on tpit_pkg.
module tpit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [63:0] time_or_start,
	input  logic [63:0] end_time,
	input  logic [7:0]  cpu_num,
	input  logic [3:0]  crit_mode,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic        inside_res,
	input  logic        has_interval,
	input  logic [3:0]  slot,
	input  logic [63:0] cycle_base,
	input  logic [63:0] iv_start,
	input  logic [63:0] iv_end,
	input  logic [7:0]  iv_cpu,
	input  logic        ends_cycle,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);
	import tpit_pkg::*;

	localparam int NM = NUM_MODES_DEF;
	localparam int SP = SLOTS_PER_MODE_DEF;
	localparam logic [3:0] ADDR_MAJOR  = 4'd0;
	localparam logic [3:0] ADDR_PERIOD = 4'd8;

	typedef struct packed {
		logic [2:0]  status;
		logic        inside_res;
		logic        has_interval;
		logic [3:0]  slot;
		logic [63:0] cycle_base;
		logic [63:0] iv_start;
		logic [63:0] iv_end;
		logic [7:0]  iv_cpu;
		logic        ends_cycle;
	} table_result_t;

	logic [63:0] major_len, period;
	logic [63:0] tbl_start [NM*SP];
	logic [63:0] tbl_end [NM*SP];
	logic [7:0]  tbl_cpu [NM*SP];
	int          tbl_count [NM];
	int          tables_made;
	table_result_t expected_results [$];

	function automatic logic [63:0] cycle_len();
		return (major_len == 0) ? 64'd1 : major_len;
	endfunction

	function automatic logic [2:0] insert_interval(logic [63:0] st, logic [63:0] en,
		logic [7:0] cpu);
		logic [63:0] m, md;
		int mode, cnt, pos, b;
		m = cycle_len();
		if (st >= en) return ST_ORDER;
		if (en / m != st / m) return ST_MAJOR;
		if (period != 0 && en / period != st / period) return ST_PERIOD;
		md = st / m;
		if (md >= NM) return ST_FULL;
		mode = int'(md);
		if (tables_made < mode + 1) tables_made = mode + 1;
		st -= md * m;
		en -= md * m;
		b = mode * SP;
		cnt = tbl_count[mode];
		pos = cnt;
		for (int i = 0; i < cnt; i++) begin
			if (tbl_start[b+i] > st) begin
				pos = i;
				break;
			end
		end
		if (pos < cnt && en > tbl_start[b+pos]) return ST_OVERLAP;
		if (pos > 0 && tbl_end[b+pos-1] > st) return ST_OVERLAP;
		if (cnt >= SP) return ST_FULL;
		for (int i = cnt; i > pos; i--) begin
			tbl_start[b+i] = tbl_start[b+i-1];
			tbl_end[b+i] = tbl_end[b+i-1];
			tbl_cpu[b+i] = tbl_cpu[b+i-1];
		end
		tbl_start[b+pos] = st;
		tbl_end[b+pos] = en;
		tbl_cpu[b+pos] = cpu;
		tbl_count[mode] = cnt + 1;
		return ST_OK;
	endfunction

	function automatic table_result_t lookup_interval(logic [63:0] t, int mode);
		table_result_t r;
		logic [63:0] m, cbase, delay, off, s, e, best_cycle;
		logic found, in_iv;
		int b, cnt, best;
		r = '0;
		m = cycle_len();
		cbase = t - (t % m);
		delay = ALL_ONES;
		found = 0;
		in_iv = 0;
		best = 0;
		best_cycle = 0;
		if (mode >= tables_made || mode >= NM) return r;
		b = mode * SP;
		cnt = tbl_count[mode];
		for (int i = 0; i < cnt; i++) begin
			off = tbl_start[b+i];
			s = cbase + off;
			e = cbase + tbl_end[b+i];
			if (e < t) begin
				s += m;
				e += m;
			end
			if (s <= t || s - t < delay) begin
				found = 1;
				best = i;
				best_cycle = s - off;
				if (s <= t) begin
					in_iv = 1;
					break;
				end
				delay = s - t;
			end
			if (cbase + off > t) break;
		end
		if (!found) return r;
		r.inside_res = in_iv;
		r.has_interval = 1;
		r.slot = best[3:0];
		r.cycle_base = best_cycle;
		r.iv_start = tbl_start[b+best];
		r.iv_end = tbl_end[b+best];
		r.iv_cpu = tbl_cpu[b+best];
		r.ends_cycle = (best + 1 == cnt);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_result_t exp_r, act_r;
		if (!arst_n) begin
			major_len = MAJOR_RESET;
			period = PERIOD_RESET;
			tables_made = 0;
			for (int i = 0; i < NM; i++) tbl_count[i] = 0;
			expected_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_MAJOR) major_len = pwdata;
				else if (paddr == ADDR_PERIOD) period = pwdata;
			end
			if (out_valid && !out_stall) begin
				act_r = '{status, inside_res, has_interval, slot, cycle_base, iv_start,
					iv_end, iv_cpu, ends_cycle};
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result transaction: %p", act_r);
				end else begin
					exp_r = expected_results.pop_front();
					if (act_r.status !== exp_r.status ||
						act_r.inside_res !== exp_r.inside_res ||
						act_r.has_interval !== exp_r.has_interval ||
						act_r.slot !== exp_r.slot ||
						act_r.cycle_base !== exp_r.cycle_base ||
						act_r.iv_start !== exp_r.iv_start ||
						act_r.iv_end !== exp_r.iv_end ||
						act_r.iv_cpu !== exp_r.iv_cpu ||
						act_r.ends_cycle !== exp_r.ends_cycle) begin
						errors++;
						if (errors <= 10)
							$display("mismatch at %0t\n  expected %p\n  actual   %p",
								$realtime, exp_r, act_r);
					end
				end
			end
			if (in_valid && !in_stall) begin
				exp_r = '0;
				case (req_type)
					REQ_ADD: exp_r.status = insert_interval(time_or_start, end_time, cpu_num);
					REQ_FIND: exp_r = lookup_interval(time_or_start, int'(crit_mode));
					REQ_CLEAR: begin
						for (int i = 0; i < NM; i++) tbl_count[i] = 0;
						tables_made = 0;
					end
					default: ;
				endcase
				expected_results.push_back(exp_r);
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> tb/time_partition_interval_table_unit_tb.sv
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, register writes, request stimulus and receiver stalls.
// Depends on tpit_pkg, tpit_checker and the time_partition_interval_table_unit RTL.
module time_partition_interval_table_unit_tb;
	import tpit_pkg::*;

	localparam logic [3:0] ADDR_MAJOR  = 4'd0;
	localparam logic [3:0] ADDR_PERIOD = 4'd8;
	localparam logic [1:0] REQ_BAD     = 2'd3;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0, in_stall;
	logic [1:0]  req_type = 0;
	logic [63:0] time_or_start = 0, end_time = 0;
	logic [7:0]  cpu_num = 0;
	logic [3:0]  crit_mode = 0;
	logic        out_valid, out_stall = 0;
	logic [2:0]  status;
	logic        inside_res, has_interval, ends_cycle;
	logic [3:0]  slot;
	logic [63:0] cycle_base, iv_start, iv_end, prdata;
	logic [7:0]  iv_cpu;
	logic        psel = 0, penable = 0, pwrite = 0, pready;
	logic [3:0]  paddr = 0;
	logic [63:0] pwdata = 0;
	int          errors, pending;
	int          tx_idle_pct = 0, rx_stall_pct = 0;
	logic        hold_on = 0;
	logic [63:0] cyc;

	always #5 clk = ~clk;

	time_partition_interval_table_unit DUT (.*);
	tpit_checker u_checker (.*);

	always @(posedge clk) out_stall <= hold_on || ($urandom_range(99) < rx_stall_pct);

	task automatic send_request(logic [1:0] rt, logic [63:0] ts, logic [63:0] et,
		logic [7:0] cpu, logic [3:0] cm);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_type <= rt;
		time_or_start <= ts;
		end_time <= et;
		cpu_num <= cpu;
		crit_mode <= cm;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(logic [3:0] addr, logic [63:0] data);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly well-formed adds and finds inside the four mode tables, with some noise.
	task automatic random_requests(int n);
		logic [63:0] s, t;
		int mode, kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(99);
			mode = ($urandom_range(9) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 3);
			if (cyc == ALL_ONES) begin
				s = rand64();
				t = rand64();
				if (kind < 45) send_request(REQ_ADD, s >> 2, (s >> 2) + (t >> 6),
					8'($urandom), 4'($urandom));
				else if (kind < 90) send_request(REQ_FIND, t, rand64(), 8'($urandom),
					4'($urandom_range(0, 1)));
				else if (kind < 95) send_request(REQ_CLEAR, t, s, 8'($urandom),
					4'($urandom));
				else send_request(2'($urandom), rand64(), rand64(), 8'($urandom),
					4'($urandom));
			end else begin
				s = 64'(mode) * cyc + 64'($urandom_range(0, int'(cyc) - 1));
				t = s + 64'($urandom_range(1, int'(cyc) / 8 + 1));
				if (kind < 50) send_request(REQ_ADD, s, t, 8'($urandom), 4'($urandom));
				else if (kind < 88) send_request(REQ_FIND,
					64'($urandom_range(0, 8 * int'(cyc))), 0, 0,
					4'(($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 4)));
				else if (kind < 92) send_request(REQ_CLEAR, 0, 0, 0, 0);
				else if (kind < 96) send_request(REQ_ADD, rand64(), rand64(), 8'($urandom),
					4'($urandom));
				else send_request(2'($urandom), rand64(), rand64(), 8'($urandom),
					4'($urandom));
			end
		end
	endtask

	initial begin
		#50ms;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		cyc = MAJOR_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed checks with the reset configuration.
		send_request(REQ_FIND, 64'd5, 0, 0, 4'd0);
		send_request(REQ_ADD, 64'd100, 64'd100, 8'hff, 0);
		send_request(REQ_ADD, ALL_ONES, 64'd0, 0, 0);
		send_request(REQ_ADD, 64'd999_990, 64'd1_000_010, 0, 0);
		send_request(REQ_ADD, 64'd4_000_000, 64'd4_000_010, 0, 0);
		send_request(REQ_ADD, 64'd2_000_100, 64'd2_000_200, 8'haa, 0);
		send_request(REQ_FIND, 64'd100, 0, 0, 4'd1);
		send_request(REQ_ADD, 64'd2_000_150, 64'd2_000_300, 0, 0);
		send_request(REQ_ADD, 64'd2_000_050, 64'd2_000_120, 0, 0);
		send_request(REQ_ADD, 64'd2_000_300, 64'd2_000_400, 8'h55, 0);
		send_request(REQ_FIND, 64'd7_000_150, 0, 0, 4'd2);
		send_request(REQ_FIND, 64'd7_000_250, 0, 0, 4'd2);
		send_request(REQ_FIND, 64'd7_000_500, 0, 0, 4'd2);
		send_request(REQ_FIND, ALL_ONES, 0, 0, 4'd2);
		send_request(REQ_FIND, 64'd7_000_150, 0, 0, 4'd15);
		send_request(REQ_FIND, 64'd7_000_150, 0, 0, 4'd3);
		send_request(REQ_BAD, ALL_ONES, ALL_ONES, 8'hff, 4'hf);
		for (int i = 0; i < 17; i++)
			send_request(REQ_ADD, 64'd10 * i, 64'd10 * i + 5, 8'(i), 0);
		send_request(REQ_CLEAR, 0, 0, 0, 0);
		send_request(REQ_FIND, 64'd7, 0, 0, 4'd0);

		// Long receiver hold-off while requests keep coming.
		hold_on <= 1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_on <= 0;
			end
			random_requests(8);
		join

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin cyc = 1000; write_reg(ADDR_MAJOR, cyc); write_reg(ADDR_PERIOD, 0); end
				1: begin write_reg(ADDR_PERIOD, 64'd300); end
				2: begin write_reg(ADDR_MAJOR, 0); cyc = 64; write_reg(ADDR_MAJOR, 1); end
				3: begin cyc = ALL_ONES; write_reg(ADDR_MAJOR, ALL_ONES);
					write_reg(ADDR_PERIOD, ALL_ONES); end
				4: begin cyc = 50; write_reg(ADDR_MAJOR, cyc); write_reg(ADDR_PERIOD, 0); end
				default: begin cyc = 1000; write_reg(ADDR_MAJOR, cyc); end
			endcase
			send_request(REQ_CLEAR, 0, 0, 0, 0);
			for (int j = 0; j < 4; j++) begin
				case (j)
					0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
					1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
					2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
					default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
				endcase
				random_requests((ph == 2) ? 25 : 45);
			end
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
